// File: rtl/core/rcpd_pkg.sv
// ----------------------------------------------------------------------------
// rcpd_pkg
// Shared constants for the robot command packet decoder: defaults, register
// addresses and status codes.
// ----------------------------------------------------------------------------
package rcpd_pkg;

  localparam int PACKET_BYTES_DEF = 64;

  // Register map, selected by paddr bit 2.
  localparam logic REG_ROBOT_ID = 1'b0;
  localparam logic REG_MAX_KICK = 1'b1;

  localparam logic [3:0] ROBOT_ID_RST = 4'd1;
  localparam logic [7:0] MAX_KICK_RST = 8'd127;
  localparam logic [7:0] KICK_SAT     = 8'd127;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_ADDR = 2'd1;
  localparam logic [1:0] ST_NO_SLOT  = 2'd2;

  // Slot position and robot mask geometry.
  localparam int POS_W = 4;
  localparam int VEC_W = 12;

endpackage

// File: rtl/core/rcpd_buf.sv
// ----------------------------------------------------------------------------
// rcpd_buf
// Packet byte buffer: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module rcpd_buf #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/rcpd_alu.sv
// ----------------------------------------------------------------------------
// rcpd_alu
// Shared adder with a bound compare against the received byte count. Used for
// the slot count, the slot range checks and every slot byte address.
// ----------------------------------------------------------------------------
module rcpd_alu #(
  parameter int XW = 7,
  parameter int IW = 7
) (
  input  logic [XW-1:0] a,
  input  logic [XW-1:0] b,
  input  logic [IW-1:0] count,
  output logic [XW-1:0] sum,
  output logic          lt
);

  assign sum = a + b;
  assign lt  = sum < XW'(count);

endmodule

// File: rtl/core/robot_command_packet_decoder.sv
// ----------------------------------------------------------------------------
// robot_command_packet_decoder
// Buffers a radio command packet and, on its last byte, decodes this robot's
// slot: dribbler, kick type and strength, and three sign-magnitude speeds.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload
//  in_      in   tdata[7:0] packet byte, tlast marks the final byte
//  out_     out  tuser status, tdata slot fields (one request per packet)
//  cfg_     in   APB registers: 0x0 robot_id, 0x4 max_kick_strength
//
// Non-final bytes are accepted back to back. The final byte starts a decode
// sequence that reads the buffer one byte per cycle through its single read
// port and runs the slot count through the shared adder one bit per cycle:
// in_tready stays low until the decode ends, earlier when the robot is not
// addressed or the slot check fails, and while a finished result waits for
// the output register. Reset is synchronous; the buffer is not cleared.
// ----------------------------------------------------------------------------
module robot_command_packet_decoder #(
  parameter int PACKET_BYTES = rcpd_pkg::PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] packet_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [2:0] dribble, [3] kick_is_chip,
                                  // [11:4] kick_strength, [21:12] speed_x,
                                  // [31:22] speed_y, [41:32] rot_speed
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import rcpd_pkg::*;

  localparam int AW = $clog2(PACKET_BYTES);
  localparam int IW = $clog2(PACKET_BYTES + 1);
  localparam int XW = (IW > 6) ? IW : 6;

  typedef enum logic [2:0] {
    S_IDLE, S_ADDR1, S_ADDR2, S_ADDRCHK, S_POP, S_CHK1, S_CHK2, S_RD
  } state_t;

  // ---------------- configuration ----------------
  logic [3:0] robot_id_r;
  logic [7:0] max_kick_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      robot_id_r <= ROBOT_ID_RST;
      max_kick_r <= MAX_KICK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ROBOT_ID: robot_id_r <= cfg_pwdata[3:0];
        REG_MAX_KICK: max_kick_r <= cfg_pwdata[7:0];
        default:      robot_id_r <= robot_id_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_ROBOT_ID: cfg_prdata = {28'd0, robot_id_r};
      REG_MAX_KICK: cfg_prdata = {24'd0, max_kick_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- datapath ----------------
  state_t           state_r;
  logic [IW-1:0]    count_r;
  logic [3:0]       b1_r;
  logic [VEC_W-1:0] vec_r;
  logic [POS_W-1:0] pos_r;
  logic [3:0]       k_r;
  logic [2:0]       j_r;
  logic [1:0]       status_r;
  logic             done_r;
  logic [7:0]       cap_r [6];
  logic             out_valid_r;
  logic [47:0]      out_data_r;
  logic [1:0]       out_user_r;

  logic             in_acc;
  logic             wr_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  logic [XW-1:0]    alu_a;
  logic [XW-1:0]    alu_b;
  logic [XW-1:0]    alu_sum;
  logic             alu_lt;
  logic [3:0]       id_m1;
  logic             id_ok;
  logic [VEC_W-1:0] vec_nxt;
  logic [XW-1:0]    pos4;
  logic [47:0]      fields;
  logic             out_free;

  assign in_tready = (state_r == S_IDLE) && !done_r;
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = in_acc && (count_r < IW'(PACKET_BYTES));
  assign id_m1     = robot_id_r - 4'd1;
  assign id_ok     = (robot_id_r >= 4'd1) && (robot_id_r <= 4'd12);
  assign vec_nxt   = {b1_r, ((count_r > IW'(2)) ? rd_data : 8'd0)};
  assign pos4      = XW'({pos_r, 2'b00});
  assign out_free  = !out_valid_r || out_tready;

  rcpd_buf #(.DEPTH(PACKET_BYTES), .AW(AW)) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rcpd_alu #(.XW(XW), .IW(IW)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .count (count_r),
    .sum   (alu_sum),
    .lt    (alu_lt)
  );

  // Operand selection for the shared adder. Slot bytes sit at 4*pos+3..+6,
  // the shared speed byte at pos+15 and the strength byte at pos+18.
  always_comb begin
    alu_a = XW'(pos_r);
    alu_b = '0;
    unique case (state_r)
      S_POP:  alu_b = XW'(vec_r[k_r]);
      S_CHK1: begin
        alu_a = pos4;
        alu_b = XW'(6);
      end
      S_CHK2: alu_b = XW'(18);
      S_RD: begin
        unique case (j_r)
          3'd4:    alu_b = XW'(15);
          3'd5:    alu_b = XW'(18);
          default: begin
            alu_a = pos4;
            alu_b = XW'(j_r) + XW'(3);
          end
        endcase
      end
      default: alu_b = '0;
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_IDLE, S_ADDR1: rd_addr = AW'(1);
      S_ADDR2:         rd_addr = AW'(2);
      default:         rd_addr = alu_sum[AW-1:0];
    endcase
  end

  function automatic logic [9:0] sm_speed(input logic [7:0] b, input logic [1:0] hi);
    logic [9:0] mag;
    mag = {1'b0, hi, b[6:0]};
    return b[7] ? 10'(10'd0 - mag) : mag;
  endfunction

  always_comb begin
    logic [2:0] drib;
    logic [7:0] ks;
    drib = {1'b0, cap_r[0][5:4]};
    if (cap_r[0][7]) begin
      drib = 3'(3'd0 - drib);
    end
    ks = (cap_r[5] >= KICK_SAT) ? max_kick_r : cap_r[5];
    fields = {6'd0,
              sm_speed(cap_r[3], cap_r[4][3:2]),
              sm_speed(cap_r[2], cap_r[4][5:4]),
              sm_speed(cap_r[1], cap_r[4][7:6]),
              ks, cap_r[0][6], drib};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
      k_r         <= '0;
      j_r         <= '0;
      pos_r       <= '0;
    end else begin
      // A finished decode waits here until the output register is free.
      if (done_r && out_free) begin
        out_valid_r <= 1'b1;
        out_user_r  <= status_r;
        out_data_r  <= (status_r == ST_OK) ? fields : 48'd0;
        done_r      <= 1'b0;
        count_r     <= '0;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (wr_en) begin
              count_r <= count_r + IW'(1);
            end
            if (in_tlast) begin
              state_r <= S_ADDR1;
            end
          end
        end
        S_ADDR1: state_r <= S_ADDR2;
        S_ADDR2: begin
          b1_r    <= (count_r > IW'(1)) ? rd_data[3:0] : 4'd0;
          state_r <= S_ADDRCHK;
        end
        S_ADDRCHK: begin
          vec_r <= vec_nxt;
          pos_r <= '0;
          k_r   <= '0;
          if (id_ok && vec_nxt[id_m1]) begin
            state_r <= S_POP;
          end else begin
            status_r <= ST_NOT_ADDR;
            done_r   <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        S_POP: begin
          if (k_r == id_m1) begin
            state_r <= S_CHK1;
          end else begin
            pos_r <= alu_sum[POS_W-1:0];
            k_r   <= k_r + 4'd1;
          end
        end
        S_CHK1, S_CHK2: begin
          if (!alu_lt) begin
            status_r <= ST_NO_SLOT;
            done_r   <= 1'b1;
            state_r  <= S_IDLE;
          end else if (state_r == S_CHK1) begin
            state_r <= S_CHK2;
          end else begin
            j_r     <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          // Read issued at step j returns at step j+1.
          if (j_r != 3'd0) begin
            cap_r[3'(j_r - 3'd1)] <= rd_data;
          end
          if (j_r == 3'd6) begin
            status_r <= ST_OK;
            done_r   <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            j_r <= j_r + 3'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
